// ===== rtl/core/rv32ie_pkg.sv =====
// rv32ie_pkg: shared constants, codes and types of the RV32I execute block.
// Used by rv32ie_exec and rv32i_instruction_execute_top; no dependencies.
`default_nettype none
package rv32ie_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  localparam int unsigned ROW_W     = ADDR_W - 2;
  localparam int unsigned ROWS      = MEM_BYTES / 4;

  // request kinds
  localparam logic [1:0] REQ_PRELOAD = 2'd0;
  localparam logic [1:0] REQ_EXEC    = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ECALL   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_END     = 2'd3;

  // opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_NOP2F  = 7'h2F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic CFG_PROG_BYTES = 1'b0;

  typedef struct packed {
    logic [1:0]  status;
    logic        wr;
    logic [31:0] val;
    logic [31:0] npc;
    logic        load;
    logic        store;
    logic [2:0]  f3;
    logic [31:0] addr;
  } exec_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/rv32ie_ram.sv =====
// rv32ie_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none
module rv32ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/core/rv32ie_exec.sv =====
// rv32ie_exec: decode and execute one instruction from operands and pc.
// Depends on rv32ie_pkg.
`default_nettype none
module rv32ie_exec (
  input  wire logic [31:0]           instr_i,
  input  wire logic [31:0]           pc_i,
  input  wire logic [31:0]           rs1_i,
  input  wire logic [31:0]           rs2_i,
  output rv32ie_pkg::exec_res_t      res_o
);
  import rv32ie_pkg::*;

  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immj, y, upper;
  logic [4:0]  sh;
  logic        take, lts, ltu;

  always_comb begin
    op    = instr_i[6:0];
    f3    = instr_i[14:12];
    f7    = instr_i[31:25];
    immi  = {{20{instr_i[31]}}, instr_i[31:20]};
    imms  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
    immb  = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
    immj  = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21],
             1'b0};
    upper = {instr_i[31:12], 12'h000};
    y     = (op == OP_REG) ? rs2_i : immi;
    sh    = y[4:0];
    lts   = $signed(rs1_i) < $signed(y);
    ltu   = rs1_i < y;
    take  = 1'b0;

    res_o        = '0;
    res_o.status = ST_OK;
    res_o.npc    = pc_i + 32'd4;
    res_o.f3     = f3;

    case (op)
      OP_REG, OP_IMM: begin
        res_o.wr = 1'b1;
        case (f3)
          F3_ADD: begin
            if (op == OP_IMM || f7 == F7_BASE) res_o.val = rs1_i + y;
            else if (f7 == F7_ALT) res_o.val = rs1_i - y;
            else res_o.status = ST_ILLEGAL;
          end
          F3_SLL:  res_o.val = rs1_i << sh;
          F3_SLT:  res_o.val = {31'd0, lts};
          F3_SLTU: res_o.val = {31'd0, ltu};
          F3_XOR:  res_o.val = rs1_i ^ y;
          F3_SR: begin
            if (op == OP_IMM) begin
              res_o.val = immi[10] ? 32'($signed(rs1_i) >>> sh) : rs1_i >> sh;
            end else if (f7 == F7_BASE) begin
              res_o.val = rs1_i >> sh;
            end else if (f7 == F7_ALT) begin
              res_o.val = 32'($signed(rs1_i) >>> sh);
            end else begin
              res_o.status = ST_ILLEGAL;
            end
          end
          F3_OR:   res_o.val = rs1_i | y;
          default: res_o.val = rs1_i & y;
        endcase
      end
      OP_NOP2F: ;
      OP_LOAD: begin
        res_o.wr   = 1'b1;
        res_o.load = 1'b1;
        res_o.addr = rs1_i + immi;
        if (!(f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU || f3 == F3_LHU))
          res_o.status = ST_ILLEGAL;
      end
      OP_STORE: begin
        res_o.store = 1'b1;
        res_o.addr  = rs1_i + imms;
        if (f3 > F3_LW) res_o.status = ST_ILLEGAL;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = rs1_i == rs2_i;
          F3_BNE:  take = rs1_i != rs2_i;
          F3_BLT:  take = $signed(rs1_i) < $signed(rs2_i);
          F3_BGE:  take = !($signed(rs1_i) < $signed(rs2_i));
          F3_BLTU: take = rs1_i < rs2_i;
          F3_BGEU: take = rs1_i >= rs2_i;
          default: res_o.status = ST_ILLEGAL;
        endcase
        if (take) res_o.npc = pc_i + immb;
      end
      OP_JAL: begin
        res_o.wr  = 1'b1;
        res_o.val = pc_i + 32'd4;
        res_o.npc = pc_i + immj;
      end
      OP_JALR: begin
        res_o.wr  = 1'b1;
        res_o.val = pc_i + 32'd4;
        res_o.npc = (rs1_i + immi) & ~32'd1;
      end
      OP_LUI: begin
        res_o.wr  = 1'b1;
        res_o.val = upper;
      end
      OP_AUIPC: begin
        res_o.wr  = 1'b1;
        res_o.val = pc_i + upper;
      end
      OP_SYSTEM: begin
        if (instr_i[31:20] == 12'd0) res_o.status = ST_ECALL;
      end
      default: res_o.status = ST_ILLEGAL;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/rv32i_instruction_execute_top.sv =====
// rv32i_instruction_execute_top: RV32I execute block with RAM register file
// and four byte-lane data RAMs. Depends on rv32ie_pkg, rv32ie_ram, rv32ie_exec.
//
//  port group   dir  content
//  s_axis_*     in   requests: tuser = req_type, tdata = instruction/preload/read
//  m_axis_*     out  results: status, next_pc, reg_written, reg_number, reg_value
//  APB          in   program_bytes at address 0
//
// A request passes through register file read on accept, execute with
// data memory access, then load merge and register writeback.
// A new request is taken in the writeback cycle, not while one is in execute;
// the register file read-after-write path is forwarded.
// A stalled result holds writeback and input acceptance until it is taken.
// Reset clears control, pc, halt state and the register valid bits; no
// memory clearing pass is needed.
`default_nettype none
module rv32i_instruction_execute_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] instr_word, [47:32] mem_address, [79:48] mem_word, [84:80] reg_select
  input  wire logic [87:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [33:2] next_pc, [34] reg_written, [39:35] reg_number,
  // [71:40] reg_value
  output logic [71:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rv32ie_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EX   = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        accept, wb_go, wb_exit;
  logic [16:0] prog_bytes_q;

  logic [1:0]  in_req;
  logic [31:0] in_instr;
  logic [4:0]  rs1_idx, rs2_idx;

  logic [1:0]  req_q;
  logic [31:0] instr_q, mword_q, pc_q;
  logic [15:0] maddr_q;
  logic [4:0]  rs1_idx_q, rs2_idx_q;
  logic        v1_q, v2_q;
  logic [31:0] rf_valid_q;
  logic [1:0]  halt_code_q;

  logic        last_wr_q;
  logic [4:0]  last_rd_q;
  logic [31:0] last_val_q;

  logic [31:0] rf1_rd, rf2_rd, opa, opb;
  exec_res_t   ex;

  logic        do_exec, ex_ok, end_hit, ex_wflag;
  logic [1:0]  st_ex;

  logic [1:0]  st_wb_q;
  logic [31:0] pc_wb_q, rval_wb_q;
  logic        wflag_wb_q, load_wb_q;
  logic [4:0]  rnum_wb_q;
  logic [2:0]  f3_wb_q;
  logic [1:0]  alo_wb_q;

  logic        mem_we;
  logic [31:0] mem_waddr, mem_wdata;
  logic [2:0]  mem_nbytes;
  logic [7:0]  lane_rd [4];
  logic [31:0] ld_word, ld_val, wb_val;

  logic        out_valid_q;
  logic [71:0] out_data_q;
  logic        rf_we;

  // ---------------- input side
  assign in_req   = s_axis_tuser;
  assign in_instr = s_axis_tdata[31:0];
  assign rs1_idx  = (in_req == REQ_READ) ? s_axis_tdata[84:80] : in_instr[19:15];
  assign rs2_idx  = in_instr[24:20];

  assign wb_go         = !out_valid_q || m_axis_tready;
  assign wb_exit       = (state_q == S_WB) && wb_go;
  assign s_axis_tready = (state_q == S_IDLE) || wb_exit;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EX;
      S_EX:   state_d = S_WB;
      S_WB:   if (wb_go) state_d = accept ? S_EX : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= in_req;
      instr_q   <= in_instr;
      maddr_q   <= s_axis_tdata[47:32];
      mword_q   <= s_axis_tdata[79:48];
      rs1_idx_q <= rs1_idx;
      rs2_idx_q <= rs2_idx;
      v1_q      <= rf_valid_q[rs1_idx];
      v2_q      <= rf_valid_q[rs2_idx];
    end
  end

  // ---------------- register file, one copy per read port
  assign rf_we = wb_exit && wflag_wb_q;

  rv32ie_ram #(.Width(32), .Depth(32)) u_rf1 (
    .clk_i, .we_i(rf_we), .waddr_i(rnum_wb_q), .wdata_i(wb_val),
    .re_i(accept), .raddr_i(rs1_idx), .rdata_o(rf1_rd)
  );
  rv32ie_ram #(.Width(32), .Depth(32)) u_rf2 (
    .clk_i, .we_i(rf_we), .waddr_i(rnum_wb_q), .wdata_i(wb_val),
    .re_i(accept), .raddr_i(rs2_idx), .rdata_o(rf2_rd)
  );

  // forward the write that retired in the accept cycle
  always_comb begin
    if (last_wr_q && last_rd_q == rs1_idx_q) opa = last_val_q;
    else opa = v1_q ? rf1_rd : 32'd0;
    if (last_wr_q && last_rd_q == rs2_idx_q) opb = last_val_q;
    else opb = v2_q ? rf2_rd : 32'd0;
  end

  rv32ie_exec u_exec (
    .instr_i(instr_q), .pc_i(pc_q), .rs1_i(opa), .rs2_i(opb), .res_o(ex)
  );

  // ---------------- execute stage decisions
  always_comb begin
    do_exec  = (state_q == S_EX) && (req_q == REQ_EXEC) && (halt_code_q == ST_OK);
    ex_ok    = do_exec && (ex.status == ST_OK);
    end_hit  = ex_ok && ({15'd0, prog_bytes_q} <= ex.npc);
    ex_wflag = ex_ok && ex.wr && (instr_q[11:7] != 5'd0);
    if (!do_exec) st_ex = halt_code_q;
    else if (ex.status != ST_OK) st_ex = ex.status;
    else if (end_hit) st_ex = ST_END;
    else st_ex = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 32'd0;
      halt_code_q <= ST_OK;
    end else begin
      if (ex_ok) pc_q <= ex.npc;
      if (do_exec && st_ex != ST_OK) halt_code_q <= st_ex;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EX) begin
      st_wb_q    <= st_ex;
      pc_wb_q    <= ex_ok ? ex.npc : pc_q;
      wflag_wb_q <= ex_wflag;
      load_wb_q  <= ex_wflag && ex.load;
      f3_wb_q    <= ex.f3;
      alo_wb_q   <= ex.addr[1:0];
      if (ex_wflag) begin
        rnum_wb_q <= instr_q[11:7];
        rval_wb_q <= ex.val;
      end else if (req_q == REQ_READ) begin
        rnum_wb_q <= rs1_idx_q;
        rval_wb_q <= opa;
      end else begin
        rnum_wb_q <= 5'd0;
        rval_wb_q <= 32'd0;
      end
    end
  end

  // ---------------- data memory, four byte lanes
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = ex.addr;
    mem_wdata  = opb;
    mem_nbytes = 3'd4;
    if (state_q == S_EX && req_q == REQ_PRELOAD) begin
      mem_we    = 1'b1;
      mem_waddr = {16'd0, maddr_q};
      mem_wdata = mword_q;
    end else if (ex_ok && ex.store) begin
      mem_we = 1'b1;
      case (ex.f3)
        F3_LB:   mem_nbytes = 3'd1;
        F3_LH:   mem_nbytes = 3'd2;
        default: mem_nbytes = 3'd4;
      endcase
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]       woff;
    logic             lwe;
    logic [ROW_W-1:0] wrow, rrow;
    logic [7:0]       lwd;
    logic [31:0]      shifted;

    assign woff    = 2'(k) - mem_waddr[1:0];
    assign lwe     = mem_we && ({1'b0, woff} < mem_nbytes);
    assign wrow    = mem_waddr[ADDR_W-1:2] + ROW_W'(2'(k) < mem_waddr[1:0]);
    assign rrow    = ex.addr[ADDR_W-1:2] + ROW_W'(2'(k) < ex.addr[1:0]);
    assign shifted = mem_wdata >> {woff, 3'b000};
    assign lwd     = shifted[7:0];

    rv32ie_ram #(.Width(8), .Depth(ROWS)) u_mem (
      .clk_i, .we_i(lwe), .waddr_i(wrow), .wdata_i(lwd),
      .re_i(state_q == S_EX), .raddr_i(rrow), .rdata_o(lane_rd[k])
    );
  end

  // ---------------- writeback: merge load bytes
  always_comb begin
    ld_word = {lane_rd[2'(alo_wb_q + 2'd3)], lane_rd[2'(alo_wb_q + 2'd2)],
               lane_rd[2'(alo_wb_q + 2'd1)], lane_rd[alo_wb_q]};
    case (f3_wb_q)
      F3_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      F3_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      F3_LBU:  ld_val = {24'd0, ld_word[7:0]};
      F3_LHU:  ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
    wb_val = load_wb_q ? ld_val : rval_wb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q  <= '0;
      last_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rf_we) rf_valid_q[rnum_wb_q] <= 1'b1;
      if (wb_exit) begin
        last_wr_q   <= wflag_wb_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_exit) begin
      last_rd_q  <= rnum_wb_q;
      last_val_q <= wb_val;
      out_data_q <= {wb_val, rnum_wb_q, wflag_wb_q, pc_wb_q, st_wb_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_bytes_q <= 17'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_PROG_BYTES) begin
      prog_bytes_q <= pwdata[16:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_PROG_BYTES) ? {15'd0, prog_bytes_q} : 32'd0;

  // ---------------- assertions
  a_ex_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EX |=> state_q == S_WB)
    else $error("execute stage did not advance to writeback");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rnum_wb_q != 5'd0)
    else $error("register file write to x0");

  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == S_IDLE || wb_exit))
    else $error("request accepted while a request is in execute");

  a_halt_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_code_q != ST_OK && state_q == S_EX) |=> $stable(pc_q))
    else $error("pc moved while halted");
endmodule
`default_nettype wire

// ===== verif/rv32i_instruction_execute_top_tb.sv =====
// Self-checking testbench for rv32i_instruction_execute_top: table-driven directed requests,
// then random programs kept inside the program window, checked against an in-bench predictor.
// Depends on rv32ie_pkg and rv32i_instruction_execute_top with the RTL below it.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_execute_top_tb;
  import rv32ie_pkg::*;

  localparam int HALT_BY_ECALL   = 0;
  localparam int HALT_BY_ILLEGAL = 1;
  localparam int HALT_BY_END     = 2;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] instr;
    logic [15:0] maddr;
    logic [31:0] mword;
    logic [4:0]  sel;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rnum;
    logic [31:0] rval;
  } res_t;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rv32i_instruction_execute_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predicted core state
  logic [31:0] xreg [32];
  logic [31:0] pc_q;
  bit          halted_q;
  logic [1:0]  halt_st;
  logic [16:0] prog_len;
  logic [7:0]  dmem [int];

  res_t pending_q [$];
  int   store_addrs [$];
  bit   no_idle;
  int   n_err, n_res, n_req, n_exec, n_load, n_store, n_ctl;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(input string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endtask

  // ---------------- encoders ----------------
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [31:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm[11:0], rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [31:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [31:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [31:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // ---------------- predictor ----------------
  function automatic logic [31:0] mem_get(logic [31:0] a, int n);
    logic [31:0] v;
    int k;
    v = '0;
    for (int i = 0; i < n; i++) begin
      k = int'((a + i) & 32'hFFFF);
      if (dmem.exists(k)) v[8*i +: 8] = dmem[k];
    end
    return v;
  endfunction

  function automatic void mem_put(logic [31:0] a, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) dmem[int'((a + i) & 32'hFFFF)] = v[8*i +: 8];
  endfunction

  function automatic bit mem_valid(int e, int n);
    for (int i = 0; i < n; i++)
      if (!dmem.exists((e + i) & 16'hFFFF)) return 0;
    return 1;
  endfunction

  function automatic logic [1:0] run_instr(input logic [31:0] ins, output logic [31:0] npc,
                                           output logic wr, output logic [31:0] val);
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] a, b, y, immi, imms, immb, immj, r, ea, ld;
    logic        w, take;
    op   = ins[6:0];
    rd   = ins[11:7];
    f3   = ins[14:12];
    f7   = ins[31:25];
    a    = xreg[ins[19:15]];
    b    = xreg[ins[24:20]];
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    npc  = pc_q + 32'd4;
    wr   = 1'b0;
    val  = '0;
    r    = '0;
    w    = 1'b0;
    take = 1'b0;
    case (op)
      OP_REG, OP_IMM: begin
        y = (op == OP_REG) ? b : immi;
        w = 1'b1;
        case (f3)
          F3_ADD: begin
            if (op == OP_IMM || f7 == F7_BASE) r = a + y;
            else if (f7 == F7_ALT) r = a - y;
            else return ST_ILLEGAL;
          end
          F3_SLL:  r = a << y[4:0];
          F3_SLT:  r = {31'b0, $signed(a) < $signed(y)};
          F3_SLTU: r = {31'b0, a < y};
          F3_XOR:  r = a ^ y;
          F3_SR: begin
            if (op == OP_IMM) r = immi[10] ? $unsigned($signed(a) >>> y[4:0]) : a >> y[4:0];
            else if (f7 == F7_BASE) r = a >> y[4:0];
            else if (f7 == F7_ALT) r = $unsigned($signed(a) >>> y[4:0]);
            else return ST_ILLEGAL;
          end
          F3_OR:   r = a | y;
          default: r = a & y;
        endcase
      end
      OP_NOP2F: ;
      OP_LOAD: begin
        ea = a + immi;
        w  = 1'b1;
        case (f3)
          F3_LB: begin
            ld = mem_get(ea, 1);
            r  = {{24{ld[7]}}, ld[7:0]};
          end
          F3_LH: begin
            ld = mem_get(ea, 2);
            r  = {{16{ld[15]}}, ld[15:0]};
          end
          F3_LW:   r = mem_get(ea, 4);
          F3_LBU:  r = mem_get(ea, 1);
          F3_LHU:  r = mem_get(ea, 2);
          default: return ST_ILLEGAL;
        endcase
      end
      OP_STORE: begin
        ea = a + imms;
        if (f3 == 3'd0) mem_put(ea, b, 1);
        else if (f3 == 3'd1) mem_put(ea, b, 2);
        else if (f3 == 3'd2) mem_put(ea, b, 4);
        else return ST_ILLEGAL;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = $signed(a) < $signed(b);
          F3_BGE:  take = $signed(a) >= $signed(b);
          F3_BLTU: take = a < b;
          F3_BGEU: take = a >= b;
          default: return ST_ILLEGAL;
        endcase
        if (take) npc = pc_q + immb;
      end
      OP_JAL: begin
        w = 1'b1; r = pc_q + 32'd4; npc = pc_q + immj;
      end
      OP_JALR: begin
        w = 1'b1; r = pc_q + 32'd4; npc = (a + immi) & ~32'd1;
      end
      OP_LUI:   begin w = 1'b1; r = {ins[31:12], 12'b0}; end
      OP_AUIPC: begin w = 1'b1; r = pc_q + {ins[31:12], 12'b0}; end
      OP_SYSTEM: if (ins[31:20] == 12'd0) return ST_ECALL;
      default: return ST_ILLEGAL;
    endcase
    wr  = w && rd != 5'd0;
    val = r;
    if (wr) xreg[rd] = r;
    return ST_OK;
  endfunction

  function automatic res_t step_core(req_t q);
    res_t        o;
    logic [1:0]  st;
    logic [31:0] npc, val;
    logic        wr;
    o = '{status: halted_q ? halt_st : ST_OK, npc: '0, wr: 1'b0, rnum: '0, rval: '0};
    if (q.kind == REQ_PRELOAD) begin
      mem_put({16'b0, q.maddr}, q.mword, 4);
    end else if (q.kind == REQ_EXEC && !halted_q) begin
      st = run_instr(q.instr, npc, wr, val);
      if (st == ST_OK) begin
        pc_q = npc;
        if (wr) begin
          o.wr = 1'b1; o.rnum = q.instr[11:7]; o.rval = val;
        end
        if (pc_q >= {15'b0, prog_len}) st = ST_END;
      end
      if (st != ST_OK) begin
        halted_q = 1'b1;
        halt_st  = st;
      end
      o.status = st;
    end else if (q.kind == REQ_READ) begin
      o.rnum = q.sel;
      o.rval = xreg[q.sel];
    end
    o.npc = pc_q;
    return o;
  endfunction

  // ---------------- request generation ----------------
  function automatic req_t noise_req(logic [1:0] kind, logic [31:0] ins);
    req_t q;
    q.kind  = kind;
    q.instr = ins;
    q.maddr = 16'($urandom);
    q.mword = $urandom;
    q.sel   = 5'($urandom);
    return q;
  endfunction

  // Pick rs1/imm so that rs1 + imm lands on byte address e, modulo memory size.
  function automatic void aim_at(input int e, output logic [4:0] rs1, output int imm);
    int d;
    rs1 = 5'($urandom);
    d   = (e - int'(xreg[rs1][15:0])) & 16'hFFFF;
    if (d < 2048) imm = d;
    else if (d >= 63488) imm = d - 65536;
    else begin
      rs1 = 5'd0;
      imm = (e < 2048) ? e : e - 65536;
    end
  endfunction

  function automatic logic [31:0] jump_low(logic [4:0] rd);
    int t;
    t = 2 * $urandom_range(0, 512);
    return enc_j(32'(t - int'(pc_q)), rd);
  endfunction

  function automatic req_t gen_exec();
    int          pcv, lim, lo, hi, pick, e, n, imm, t;
    logic [4:0]  rs1, rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] ins;
    pcv  = int'(pc_q);
    lim  = int'(prog_len) - 68;
    rd   = 5'($urandom);
    pick = $urandom_range(99);
    if (pcv >= int'(prog_len) - 64) return noise_req(REQ_EXEC, jump_low(rd));
    lo = (-pcv / 2 > -2048) ? -pcv / 2 : -2048;
    hi = ((lim - pcv) / 2 < 2047) ? (lim - pcv) / 2 : 2047;
    if (pick < 20) begin
      f3 = 3'($urandom);
      if (f3 == F3_ADD || f3 == F3_SR) f7 = $urandom_range(1) ? F7_ALT : F7_BASE;
      else f7 = $urandom_range(1) ? 7'($urandom) : F7_BASE;
      ins = enc_r(f7, 5'($urandom), 5'($urandom), f3, rd, OP_REG);
    end else if (pick < 42) begin
      ins = enc_i($urandom, 5'($urandom), 3'($urandom), rd, OP_IMM);
    end else if (pick < 56) begin
      n_load++;
      case ($urandom_range(4))
        0: begin f3 = F3_LB;  n = 1; end
        1: begin f3 = F3_LBU; n = 1; end
        2: begin f3 = F3_LH;  n = 2; end
        3: begin f3 = F3_LHU; n = 2; end
        default: begin f3 = F3_LW; n = 4; end
      endcase
      if (store_addrs.size() != 0 && $urandom_range(1))
        e = store_addrs[$urandom_range(store_addrs.size() - 1)];
      else if ($urandom_range(7) == 0) e = 65536 - $urandom_range(1, 2);
      else e = $urandom_range(0, 128 - n);
      if (!mem_valid(e, n)) e = 0;
      aim_at(e, rs1, imm);
      ins = enc_i(32'(imm), rs1, f3, rd, OP_LOAD);
    end else if (pick < 68) begin
      n_store++;
      f3 = 3'($urandom_range(2));
      if ($urandom_range(9) < 3) begin
        imm = int'($urandom_range(4095)) - 2048;
        rs1 = 5'($urandom);
      end else begin
        e = $urandom_range(1) ? $urandom_range(0, 2047) : $urandom_range(63488, 65535);
        aim_at(e, rs1, imm);
      end
      e = int'((xreg[rs1] + 32'(imm)) & 32'hFFFF);
      if (e < 2048 || e >= 63488) store_addrs.push_back(e);
      ins = enc_s(32'(imm), 5'($urandom), rs1, f3);
    end else if (pick < 80) begin
      n_ctl++;
      case ($urandom_range(5))
        0: f3 = F3_BEQ;  1: f3 = F3_BNE;  2: f3 = F3_BLT;
        3: f3 = F3_BGE;  4: f3 = F3_BLTU; default: f3 = F3_BGEU;
      endcase
      t   = lo + int'($urandom_range(hi - lo));
      ins = enc_b(32'(2 * t), 5'($urandom), 5'($urandom), f3);
    end else if (pick < 85) begin
      n_ctl++;
      t   = lo + int'($urandom_range(hi - lo));
      ins = enc_j(32'(2 * t), rd);
    end else if (pick < 90) begin
      n_ctl++;
      t = 2 * $urandom_range(0, ((lim < 2046) ? lim : 2046) / 2);
      aim_at(t, rs1, imm);
      // only the low 16 bits are aimed; redo the full sum with x0 if it misses
      if (((xreg[rs1] + 32'(imm)) & ~32'd1) != 32'(t)) begin
        rs1 = 5'd0; imm = t;
      end
      if (imm < 2047 && $urandom_range(1)) imm++;
      ins = enc_i(32'(imm), rs1, 3'($urandom), rd, OP_JALR);
    end else if (pick < 94) begin
      ins = {20'($urandom), rd, OP_LUI};
    end else if (pick < 97) begin
      ins = {20'($urandom), rd, OP_AUIPC};
    end else if ($urandom_range(1)) begin
      ins = {12'($urandom_range(1, 4095)), 13'($urandom), OP_SYSTEM};
    end else begin
      ins = {25'($urandom), OP_NOP2F};
    end
    return noise_req(REQ_EXEC, ins);
  endfunction

  function automatic req_t gen_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return noise_req(REQ_PRELOAD, $urandom);
    if (pick < 14) return noise_req(REQ_READ, $urandom);
    if (pick < 16) return noise_req(2'd3, $urandom);
    return gen_exec();
  endfunction

  // ---------------- bus drivers ----------------
  task automatic send_req(input req_t q, input bit typed, input res_t want);
    res_t r;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.kind;
    s_axis_tdata  <= {3'b0, q.sel, q.mword, q.maddr, q.instr};
    do @(posedge clk_i); while (!s_axis_tready);
    r = step_core(q);
    n_req++;
    if (q.kind == REQ_EXEC) n_exec++;
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic send_rand(input req_t q);
    send_req(q, 1'b0, '{default: '0});
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_prog_len(input logic [16:0] v);
    logic [31:0] got;
    drain();
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {CFG_PROG_BYTES, 2'b00}; pwdata <= {15'b0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    prog_len = v;
    @(negedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (got !== {15'b0, v})
      report($sformatf("program_bytes readback: expected %h, got %h", {15'b0, v}, got));
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  // ---------------- result checker ----------------
  task automatic check_field(input string f, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) report($sformatf("result %0d %s: expected %h, got %h", n_res, f, e, a));
  endtask

  always @(posedge clk_i) begin : result_check
    res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", n_res));
      end else begin
        e = pending_q.pop_front();
        check_field("status", 32'(e.status), 32'(m_axis_tdata[1:0]));
        check_field("next_pc", e.npc, m_axis_tdata[33:2]);
        check_field("reg_written", 32'(e.wr), 32'(m_axis_tdata[34]));
        check_field("reg_number", 32'(e.rnum), 32'(m_axis_tdata[39:35]));
        check_field("reg_value", e.rval, m_axis_tdata[71:40]);
      end
      n_res++;
    end
  end

  // ---------------- main sequence ----------------
  row_t boot_rows [];
  row_t op_rows [];
  int   halt_mode;
  req_t q;

  initial begin
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = REQ_PRELOAD;
    m_axis_tready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0;
    pwdata = '0; no_idle = 1'b0;
    foreach (xreg[i]) xreg[i] = '0;
    pc_q = '0; halted_q = 1'b0; halt_st = ST_OK; prog_len = '0;
    n_err = 0; n_res = 0; n_req = 0; n_exec = 0; n_load = 0; n_store = 0; n_ctl = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: zero registers and pc, preload wraps around the top of memory
    set_prog_len(17'd0);
    boot_rows = '{
      '{'{REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31}, 1'b1,
        '{ST_OK, 32'd0, 1'b0, 5'd31, 32'd0}},
      '{'{REQ_READ, 32'h0, 16'h0, 32'h0, 5'd0}, 1'b1, '{ST_OK, 32'd0, 1'b0, 5'd0, 32'd0}},
      '{'{REQ_PRELOAD, 32'h0, 16'hFFFE, 32'h80FF_7F01, 5'd0}, 1'b1,
        '{ST_OK, 32'd0, 1'b0, 5'd0, 32'd0}},
      '{'{2'd3, 32'hFFFF_FFFF, 16'h1234, 32'h0, 5'd17}, 1'b1,
        '{ST_OK, 32'd0, 1'b0, 5'd0, 32'd0}}
    };
    foreach (boot_rows[i]) send_req(boot_rows[i].rq, boot_rows[i].typed, boot_rows[i].want);
    for (int a = 4; a < 128; a += 4) begin
      q       = noise_req(REQ_PRELOAD, $urandom);
      q.maddr = 16'(a);
      send_rand(q);
    end
    send_rand('{REQ_PRELOAD, 32'h0, 16'h0000, 32'h0080_7FFF, 5'd0});

    set_prog_len(17'h10000);
    op_rows = '{
      '{noise_req(REQ_EXEC, enc_i(32'hFFFF_F800, 5'd0, F3_ADD, 5'd1, OP_IMM)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'd2047, 5'd0, F3_ADD, 5'd2, OP_IMM)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, {20'hFFFFF, 5'd3, OP_LUI}), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, {20'h00001, 5'd4, OP_AUIPC}), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd31, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd6, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd2, 5'd3, F3_SLL, 5'd7, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd8, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(7'h7F, 5'd2, 5'd1, F3_SLTU, 5'd9, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd2, 5'd3, F3_XOR, 5'd10, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd2, 5'd3, F3_SR, 5'd11, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_ALT, 5'd2, 5'd3, F3_SR, 5'd12, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd1, 5'd2, F3_OR, 5'd13, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_r(F7_BASE, 5'd1, 5'd3, F3_AND, 5'd14, OP_REG)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'h41F, 5'd3, F3_SR, 5'd15, OP_IMM)), 1'b0, '{default: '0}},
      // write to x0 is dropped and reported as no write
      '{noise_req(REQ_EXEC, enc_i(32'd5, 5'd1, F3_ADD, 5'd0, OP_IMM)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, 32'h0010_0073), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, 32'hFFFF_FFAF), 1'b0, '{default: '0}},
      // loads at and across the top of memory
      '{noise_req(REQ_EXEC, enc_i(32'hFFE, 5'd0, F3_LH, 5'd16, OP_LOAD)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'hFFE, 5'd0, F3_LW, 5'd17, OP_LOAD)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'hFFF, 5'd0, F3_LBU, 5'd18, OP_LOAD)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'd0, 5'd0, F3_LB, 5'd19, OP_LOAD)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_s(32'hFFE, 5'd3, 5'd0, 3'd2)), 1'b0, '{default: '0}},
      // jalr with rd equal to rs1 must use the old rs1
      '{noise_req(REQ_EXEC, enc_i(32'd200, 5'd0, F3_ADD, 5'd20, OP_IMM)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_i(32'd9, 5'd20, 3'd5, 5'd20, OP_JALR)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_j(32'd8, 5'd21)), 1'b0, '{default: '0}},
      '{noise_req(REQ_EXEC, enc_b(32'hFFFF_FFFC, 5'd2, 5'd1, F3_BLT)), 1'b0, '{default: '0}}
    };
    foreach (op_rows[i]) send_req(op_rows[i].rq, op_rows[i].typed, op_rows[i].want);

    for (int i = 0; i < 600; i++) begin
      no_idle = (i >= 200 && i < 350);
      if (i == 100) drain();
      send_rand(gen_req());
    end
    no_idle = 1'b0;

    // move the program low before narrowing the window
    send_rand(noise_req(REQ_EXEC, jump_low(5'($urandom))));
    set_prog_len(17'd4096);
    for (int i = 0; i < 480; i++) send_rand(gen_req());

    halt_mode = $urandom_range(HALT_BY_END);
    case (halt_mode)
      HALT_BY_ECALL: send_rand(noise_req(REQ_EXEC, {12'd0, 13'($urandom), OP_SYSTEM}));
      HALT_BY_ILLEGAL: send_rand(noise_req(REQ_EXEC,
                                 enc_r(7'h7F, 5'($urandom), 5'($urandom), F3_ADD, 5'd1, OP_REG)));
      default: begin
        set_prog_len(17'(pc_q + 32'd4));
        send_rand(noise_req(REQ_EXEC, enc_i(32'd0, 5'd0, F3_ADD, 5'd0, OP_IMM)));
      end
    endcase
    // halted: status repeats, state holds
    for (int i = 0; i < 6; i++) begin
      q = noise_req(2'($urandom_range(2)), $urandom);
      send_rand(q);
    end
    send_rand(noise_req(REQ_READ, 32'h0));

    drain();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d requests (%0d executes: %0d loads, %0d stores, %0d jumps/branches),",
             n_req, n_exec, n_load, n_store, n_ctl);
    $display("checked %0d results, halted by mode %0d with program windows 0/64K/4K.",
             n_res, halt_mode);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
